### sv/mlfq_pkg.sv
// Package for the multilevel feedback queue scheduler: widths, codes, reset constants.
// No dependencies.
`timescale 1ns / 1ps
package mlfq_pkg;
	localparam int NUM_LEVELS = 4;
	localparam int LVL_W = 2;
	localparam int TIME_W = 16;
	localparam int ID_W = 4;
	localparam int Q_W = 8;
	localparam int MAX_PROCS_DEF = 16;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;
	localparam logic FUNC_ARRIVE = 1'b0;
	localparam logic FUNC_TICK = 1'b1;
	localparam logic [1:0] CFG_Q0 = 2'd0;
	localparam logic [1:0] CFG_Q1 = 2'd1;
	localparam logic [1:0] CFG_Q2 = 2'd2;
	localparam logic [1:0] CFG_Q3 = 2'd3;
	localparam logic [Q_W-1:0] Q_RESET [NUM_LEVELS] = '{8'd1, 8'd2, 8'd4, 8'd8};

	typedef struct packed {
		logic arrive;
		logic pick;
		logic fetch;
		logic demote;
		logic run;
	} mlfq_cmd_t;

	typedef struct packed {
		logic any_ready;
		logic has_running;
		logic slice_zero;
		logic demote_ok;
	} mlfq_stat_t;
endpackage

### sv/multilevel_feedback_queue_scheduler.sv
// Users: an arrival request is handled in the idle state; a tick request passes through the states
// accept, pick, fetch of the next queue head, requeue of an expired process with re-pick, then slot
// update, sequenced by the controller over the shared queue state and the registered queue reads. The
// result sits in an output register; a tick stalls in its slot update until the previous result
// has been handed over. The user must write quantum registers 0..3 only while the block is idle;
// the block itself does not enforce this. Depends on mlfq_pkg, mlfq_ctrl, mlfq_dp.
`timescale 1ns / 1ps
module multilevel_feedback_queue_scheduler import mlfq_pkg::*; #(
	parameter int MAX_PROCS = MAX_PROCS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // proc_id[3:0], burst_len[19:4], zero pad
	input  logic        s_tuser,  // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // tick_time, busy_res, running_id, finished,
	                              // finish_time, turnaround, waiting, zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	mlfq_cmd_t  cmd;
	mlfq_stat_t stat;
	logic       busy;
	logic       in_fire;
	logic       out_free;
	logic       mv_q;
	logic [69:0] res;

	assign s_tready = !busy;
	assign in_fire = s_tvalid && s_tready;
	assign out_free = !mv_q || m_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid = mv_q;
	assign m_tdata = {2'd0, res};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_q <= 1'b0;
		end else if (cmd.run) begin
			mv_q <= 1'b1;
		end else if (m_tready) begin
			mv_q <= 1'b0;
		end
	end

	mlfq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_func(s_tuser),
		.stat(stat), .out_free(out_free), .busy(busy), .cmd(cmd)
	);

	mlfq_dp #(.MAX_PROCS(MAX_PROCS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_id(s_tdata[3:0]),
		.in_burst(s_tdata[19:4]), .cfg_we(cfg_valid && cfg_ready), .cfg_idx(cfg_index),
		.cfg_val(cfg_data), .stat(stat), .res(res)
	);

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cmd) <= 1) else $error("multiple commands");
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		mv_q && !m_tready |=> mv_q && $stable(m_tdata)) else $error("result lost");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.run |-> !s_tready) else $error("accept during tick");
endmodule

### sv/mlfq_ctrl.sv
// Controller of the scheduler: sequences arrival and tick requests.
// Depends on mlfq_pkg.
`timescale 1ns / 1ps
module mlfq_ctrl import mlfq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_fire,
	input  logic       in_func,
	input  mlfq_stat_t stat,
	input  logic       out_free,
	output logic       busy,
	output mlfq_cmd_t  cmd
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PICK = 3'd1;
	localparam logic [2:0] ST_FETCH = 3'd2;
	localparam logic [2:0] ST_DEM = 3'd3;
	localparam logic [2:0] ST_RUN = 3'd4;
	logic [2:0] state_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: cmd.arrive = in_fire && (in_func == FUNC_ARRIVE);
			ST_PICK: cmd.pick = !stat.has_running;
			ST_FETCH: cmd.fetch = 1'b1;
			ST_DEM: cmd.demote = stat.has_running && stat.slice_zero;
			ST_RUN: cmd.run = out_free;
			default: cmd = '0;
		endcase
	end
	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (in_fire && in_func == FUNC_TICK) state_q <= ST_PICK;
				ST_PICK: state_q <= ST_FETCH;
				ST_FETCH: state_q <= ST_DEM;
				ST_DEM: state_q <= ST_RUN;
				ST_RUN: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### sv/mlfq_dp.sv
// Datapath of the scheduler: level FIFOs, process tables, time and result register.
// Depends on mlfq_pkg.
`timescale 1ns / 1ps
module mlfq_dp import mlfq_pkg::*; #(
	parameter int MAX_PROCS = MAX_PROCS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mlfq_cmd_t         cmd,
	input  logic [ID_W-1:0]   in_id,
	input  logic [TIME_W-1:0] in_burst,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_idx,
	input  logic [Q_W-1:0]    cfg_val,
	output mlfq_stat_t        stat,
	output logic [69:0]       res
);
	localparam int PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int CW = $clog2(MAX_PROCS + 1);

	logic [ID_W-1:0]   fifo_q [NUM_LEVELS][MAX_PROCS];
	logic [PW-1:0]     head_q [NUM_LEVELS];
	logic [PW-1:0]     tail_q [NUM_LEVELS];
	logic [CW-1:0]     cnt_q [NUM_LEVELS];
	logic [TIME_W-1:0] rem_q [MAX_PROCS];
	logic [TIME_W-1:0] arr_q [MAX_PROCS];
	logic [TIME_W-1:0] bur_q [MAX_PROCS];
	logic [Q_W-1:0]    quant_q [NUM_LEVELS];
	logic [TIME_W-1:0] time_q;
	logic              run_q;
	logic [ID_W-1:0]   proc_q;
	logic [LVL_W-1:0]  lvl_q;
	logic [Q_W-1:0]    slice_q;
	logic [ID_W-1:0]   head_rd_q;

	logic              any;
	logic [LVL_W-1:0]  plvl;
	logic [LVL_W-1:0]  nl;
	logic              dem_ok;
	logic              pick2;
	logic [ID_W-1:0]   pid;
	logic [LVL_W-1:0]  plvl2;
	logic [LVL_W-1:0]  rd_lvl;
	logic [PW-1:0]     p;
	logic [TIME_W-1:0] rnew;
	logic [TIME_W-1:0] comp;
	logic [TIME_W-1:0] tat;
	logic [TIME_W-1:0] wt;
	logic              arr_ok;

	function automatic logic [Q_W-1:0] qof(input logic [Q_W-1:0] q);
		qof = (q == '0) ? Q_W'(1) : q;
	endfunction

	always_comb begin
		any = 1'b0;
		plvl = '0;
		for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
			if (cnt_q[i] != '0) begin
				any = 1'b1;
				plvl = LVL_W'(i);
			end
		end
		nl = (lvl_q < 2'd3) ? lvl_q + 2'd1 : lvl_q;
		dem_ok = (cnt_q[nl] < CW'(MAX_PROCS));
		pick2 = 1'b0;
		plvl2 = nl;
		for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
			if (cnt_q[i] != '0 || LVL_W'(i) == nl) begin
				pick2 = 1'b1;
				plvl2 = LVL_W'(i);
			end
		end
		rd_lvl = cmd.fetch ? plvl2 : plvl;
		pid = (cmd.demote && plvl2 == nl && cnt_q[nl] == '0) ? proc_q : head_rd_q;
		p = PW'(proc_q);
		rnew = (rem_q[p] != '0) ? rem_q[p] - 1'b1 : '0;
		comp = (time_q < TIME_MAX) ? time_q + 1'b1 : TIME_MAX;
		tat = (comp >= arr_q[p]) ? comp - arr_q[p] : '0;
		wt = (tat >= bur_q[p]) ? tat - bur_q[p] : '0;
		arr_ok = (32'(in_id) < MAX_PROCS) && (cnt_q[0] < CW'(MAX_PROCS));
	end

	assign stat.any_ready = any;
	assign stat.has_running = run_q;
	assign stat.slice_zero = (slice_q == '0);
	assign stat.demote_ok = dem_ok;

	always_ff @(posedge clk) begin
		head_rd_q <= fifo_q[rd_lvl][head_q[rd_lvl]];
		if (cmd.arrive && arr_ok) begin
			fifo_q[0][tail_q[0]] <= in_id;
			rem_q[PW'(in_id)] <= in_burst;
			bur_q[PW'(in_id)] <= in_burst;
			arr_q[PW'(in_id)] <= time_q;
		end
		if (cmd.demote && dem_ok)
			fifo_q[nl][tail_q[nl]] <= proc_q;
		if (cmd.run && run_q)
			rem_q[p] <= rnew;
		if (cmd.run) begin
			res[15:0] <= time_q;
			res[16] <= run_q;
			res[20:17] <= run_q ? proc_q : '0;
			res[21] <= run_q && rnew == '0;
			res[37:22] <= (run_q && rnew == '0) ? comp : '0;
			res[53:38] <= (run_q && rnew == '0) ? tat : '0;
			res[69:54] <= (run_q && rnew == '0) ? wt : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i] <= '0;
				quant_q[i] <= Q_RESET[i];
			end
			time_q <= '0;
			run_q <= 1'b0;
			proc_q <= '0;
			lvl_q <= '0;
			slice_q <= '0;
		end else begin
			if (cfg_we)
				quant_q[cfg_idx] <= cfg_val;
			if (cmd.arrive && arr_ok) begin
				tail_q[0] <= (32'(tail_q[0]) == MAX_PROCS - 1) ? '0 : tail_q[0] + 1'b1;
				cnt_q[0] <= cnt_q[0] + 1'b1;
			end
			if (cmd.pick && any) begin
				head_q[plvl] <= (32'(head_q[plvl]) == MAX_PROCS - 1) ? '0 : head_q[plvl] + 1'b1;
				cnt_q[plvl] <= cnt_q[plvl] - 1'b1;
				run_q <= 1'b1;
				proc_q <= head_rd_q;
				lvl_q <= plvl;
				slice_q <= qof(quant_q[plvl]);
			end
			if (cmd.demote) begin
				if (dem_ok) begin
					tail_q[nl] <= (32'(tail_q[nl]) == MAX_PROCS - 1) ? '0 : tail_q[nl] + 1'b1;
					head_q[plvl2] <= (32'(head_q[plvl2]) == MAX_PROCS - 1) ? '0
						: head_q[plvl2] + 1'b1;
					if (plvl2 != nl) begin
						cnt_q[plvl2] <= cnt_q[plvl2] - 1'b1;
						cnt_q[nl] <= cnt_q[nl] + 1'b1;
					end
					proc_q <= pid;
					lvl_q <= plvl2;
					slice_q <= qof(quant_q[plvl2]);
				end else begin
					lvl_q <= nl;
					slice_q <= qof(quant_q[nl]);
				end
			end
			if (cmd.run) begin
				if (run_q) begin
					slice_q <= slice_q - 1'b1;
					if (rnew == '0)
						run_q <= 1'b0;
				end
				if (time_q < TIME_MAX)
					time_q <= time_q + 1'b1;
			end
		end
	end
endmodule

### sim/multilevel_feedback_queue_scheduler_test.sv
// Self-checking testbench for the four-level feedback-queue scheduler: random and directed
// arrival and tick requests, predicted slot results compared field by field.
// Depends on mlfq_pkg and multilevel_feedback_queue_scheduler.
`timescale 1ns / 1ps
module multilevel_feedback_queue_scheduler_test;
	import mlfq_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int SETTLE_CYCLES = 30;

	typedef struct packed {
		logic        func;
		logic [3:0]  pid;
		logic [15:0] burst;
	} request_t;

	typedef struct packed {
		logic [15:0] waiting;
		logic [15:0] turnaround;
		logic [15:0] completion;
		logic        finished;
		logic [3:0]  run_id;
		logic        busy;
		logic [15:0] tick_time;
	} slot_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	multilevel_feedback_queue_scheduler u_top (.*);

	always #5 clk = ~clk;

	request_t pending[$];
	slot_t    expected_slots[$];
	request_t next_req;
	logic     s_took = 1'b0;
	int       cycle_count = 0;
	int       error_count = 0;
	int       tick_count = 0;
	int       arrival_count = 0;
	int       done_count = 0;
	int       cfg_count = 0;

	// scheduler state mirror
	logic [7:0]  quantum [NUM_LEVELS];
	logic [3:0]  ready_q [NUM_LEVELS][16];
	logic [3:0]  q_head [NUM_LEVELS];
	logic [3:0]  q_tail [NUM_LEVELS];
	logic [4:0]  q_count [NUM_LEVELS];
	logic [15:0] remaining [16];
	logic [15:0] arrived_at [16];
	logic [15:0] burst_of [16];
	logic [15:0] now_time;
	logic        running;
	logic [3:0]  run_proc;
	logic [1:0]  run_lvl;
	logic [7:0]  slice_left;

	initial begin
		for (int i = 0; i < NUM_LEVELS; i++) begin
			quantum[i] = Q_RESET[i];
			q_head[i] = '0;
			q_tail[i] = '0;
			q_count[i] = '0;
		end
		now_time = '0;
		running = 1'b0;
		run_proc = '0;
		run_lvl = '0;
		slice_left = '0;
	end

	function automatic logic [7:0] slice_for(input logic [1:0] lv);
		return (quantum[lv] == 8'd0) ? 8'd1 : quantum[lv];
	endfunction

	function automatic bit level_push(input logic [1:0] lv, input logic [3:0] id);
		if (q_count[lv] >= 5'd16)
			return 1'b0;
		ready_q[lv][q_tail[lv]] = id;
		q_tail[lv] = q_tail[lv] + 4'd1;
		q_count[lv] = q_count[lv] + 5'd1;
		return 1'b1;
	endfunction

	function automatic bit level_pick(output logic [3:0] id, output logic [1:0] lv);
		id = '0;
		lv = '0;
		for (int i = 0; i < NUM_LEVELS; i++) begin
			if (q_count[i] != 0) begin
				id = ready_q[i][q_head[i]];
				q_head[i] = q_head[i] + 4'd1;
				q_count[i] = q_count[i] - 5'd1;
				lv = i[1:0];
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	task automatic schedule_request(input request_t r);
		slot_t       res;
		logic [3:0]  id;
		logic [1:0]  lv;
		logic [1:0]  nl;
		logic [16:0] comp;
		logic [16:0] tat;
		logic [16:0] wt;
		if (r.func == FUNC_ARRIVE) begin
			if (level_push(2'd0, r.pid)) begin
				remaining[r.pid] = r.burst;
				burst_of[r.pid] = r.burst;
				arrived_at[r.pid] = now_time;
			end
			return;
		end
		res = '0;
		res.tick_time = now_time;
		if (!running) begin
			if (level_pick(id, lv)) begin
				running = 1'b1;
				run_proc = id;
				run_lvl = lv;
				slice_left = slice_for(lv);
			end
		end
		if (running) begin
			if (slice_left == 8'd0) begin
				nl = (run_lvl < 2'd3) ? run_lvl + 2'd1 : run_lvl;
				if (level_push(nl, run_proc) && level_pick(id, lv)) begin
					run_proc = id;
					run_lvl = lv;
				end else begin
					run_lvl = nl;
				end
				slice_left = slice_for(run_lvl);
			end
			if (remaining[run_proc] != 16'd0)
				remaining[run_proc] = remaining[run_proc] - 16'd1;
			slice_left = slice_left - 8'd1;
			res.busy = 1'b1;
			res.run_id = run_proc;
			if (remaining[run_proc] == 16'd0) begin
				comp = (now_time != TIME_MAX) ? {1'b0, now_time} + 17'd1 : {1'b0, TIME_MAX};
				tat = (comp >= {1'b0, arrived_at[run_proc]}) ? comp - arrived_at[run_proc] : '0;
				wt = (tat >= {1'b0, burst_of[run_proc]}) ? tat - burst_of[run_proc] : '0;
				res.finished = 1'b1;
				res.completion = comp[15:0];
				res.turnaround = tat[15:0];
				res.waiting = wt[15:0];
				running = 1'b0;
			end
		end
		if (now_time != TIME_MAX)
			now_time = now_time + 16'd1;
		expected_slots.push_back(res);
	endtask

	function automatic void check_slot(input slot_t exp_s, input slot_t got);
		if (got.tick_time !== exp_s.tick_time) begin
			$error("tick_time expected %0d got %0d", exp_s.tick_time, got.tick_time);
			error_count++;
		end
		if (got.busy !== exp_s.busy) begin
			$error("busy_res expected %0d got %0d", exp_s.busy, got.busy);
			error_count++;
		end
		if (got.run_id !== exp_s.run_id) begin
			$error("running_id expected %0d got %0d", exp_s.run_id, got.run_id);
			error_count++;
		end
		if (got.finished !== exp_s.finished) begin
			$error("finished expected %0d got %0d", exp_s.finished, got.finished);
			error_count++;
		end
		if (got.completion !== exp_s.completion) begin
			$error("finish_time expected %0d got %0d", exp_s.completion, got.completion);
			error_count++;
		end
		if (got.turnaround !== exp_s.turnaround) begin
			$error("turnaround expected %0d got %0d", exp_s.turnaround, got.turnaround);
			error_count++;
		end
		if (got.waiting !== exp_s.waiting) begin
			$error("waiting expected %0d got %0d", exp_s.waiting, got.waiting);
			error_count++;
		end
	endfunction

	function automatic bit idle_now();
		if (cycle_count >= 2000 && cycle_count < 4500)
			return 1'b0;
		return $urandom_range(0, 99) < 6;
	endfunction

	// monitor: predict on accepted requests, check handed-over results
	always @(posedge clk) begin
		slot_t got;
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("multilevel_feedback_queue_scheduler verification failed");
			$finish;
		end else if (arst_n) begin
			s_took <= s_tvalid && s_tready;
			if (cfg_valid && cfg_ready) begin
				quantum[cfg_index] = cfg_data;
				cfg_count++;
			end
			if (m_tvalid && m_tready) begin
				got = slot_t'(m_tdata[69:0]);
				if (expected_slots.size() == 0) begin
					$error("result with no request outstanding, tick_time %0d", got.tick_time);
					error_count++;
				end else begin
					check_slot(expected_slots.pop_front(), got);
				end
				if (got.finished)
					done_count++;
			end
			if (s_tvalid && s_tready) begin
				next_req.func = s_tuser;
				next_req.pid = s_tdata[3:0];
				next_req.burst = s_tdata[19:4];
				if (s_tuser == FUNC_TICK)
					tick_count++;
				else
					arrival_count++;
				schedule_request(next_req);
			end
		end
	end

	// driver
	always @(negedge clk) begin
		request_t r;
		if (arst_n) begin
			if (!s_tvalid || s_took) begin
				if (pending.size() != 0 && !idle_now()) begin
					r = pending.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {4'b0, r.burst, r.pid};
					s_tuser <= r.func;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= !idle_now();
		end
	end

	task automatic add_req(input logic f, input logic [3:0] pid, input logic [15:0] burst);
		request_t r;
		r.func = f;
		r.pid = pid;
		r.burst = burst;
		pending.push_back(r);
	endtask

	task automatic write_quantum(input logic [1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_quanta(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c, input logic [7:0] d);
		write_quantum(CFG_Q0, a);
		write_quantum(CFG_Q1, b);
		write_quantum(CFG_Q2, c);
		write_quantum(CFG_Q3, d);
	endtask

	task automatic drain();
		while (pending.size() != 0 || s_tvalid || expected_slots.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_burst();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 70)
			return 16'($urandom_range(1, 8));
		if (sel < 90)
			return 16'($urandom_range(1, 300));
		return 16'($urandom_range(1, 65535));
	endfunction

	task automatic random_phase(input int n, input int arrive_pct, input int pid_hi);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < arrive_pct)
				add_req(FUNC_ARRIVE, 4'($urandom_range(0, pid_hi)), rand_burst());
			else
				add_req(FUNC_TICK, 4'($urandom_range(0, 15)), 16'($urandom));
		end
		drain();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// defaults first: extremes of ids and bursts, zero burst, repeated id
		add_req(FUNC_TICK, 4'd0, 16'd0);
		add_req(FUNC_ARRIVE, 4'd0, 16'd1);
		add_req(FUNC_ARRIVE, 4'd15, 16'hFFFF);
		add_req(FUNC_ARRIVE, 4'd5, 16'd0);
		add_req(FUNC_ARRIVE, 4'd5, 16'd3);
		add_req(FUNC_ARRIVE, 4'd10, 16'hAAAA);
		for (int i = 0; i < 8; i++)
			add_req(FUNC_TICK, 4'hF, 16'hFFFF);
		add_req(FUNC_ARRIVE, 4'd15, 16'd2);
		for (int i = 0; i < 8; i++)
			add_req(FUNC_TICK, 4'd0, 16'd0);
		drain();

		// fill level 0 past its depth, all at the shortest slice
		set_quanta(8'd1, 8'd1, 8'd1, 8'd1);
		for (int i = 0; i < 18; i++)
			add_req(FUNC_ARRIVE, i[3:0], 16'd40);
		random_phase(200, 55, 3);
		random_phase(250, 30, 15);

		set_quanta(8'd255, 8'd255, 8'd255, 8'd255);
		random_phase(250, 25, 15);

		set_quanta(8'd0, 8'd3, 8'd0, 8'd200);
		random_phase(200, 35, 7);

		set_quanta(8'd2, 8'd5, 8'd17, 8'd128);
		random_phase(250, 40, 15);

		// back to the reset quanta with sparse arrivals
		set_quanta(8'd1, 8'd2, 8'd4, 8'd8);
		for (int i = 0; i < 160; i++) begin
			if ($urandom_range(0, 99) < 30)
				add_req(FUNC_ARRIVE, 4'($urandom_range(0, 15)), rand_burst());
			else
				add_req(FUNC_TICK, 4'd0, 16'd0);
		end
		add_req(FUNC_ARRIVE, 4'd9, 16'd2);
		for (int i = 0; i < 40; i++)
			add_req(FUNC_TICK, 4'd0, 16'd0);
		drain();

		$display("Covered %0d ticks and %0d arrivals, %0d completions, %0d quantum writes.",
			tick_count, arrival_count, done_count, cfg_count);
		if (error_count == 0)
			$display("multilevel_feedback_queue_scheduler verification clean");
		else
			$display("multilevel_feedback_queue_scheduler verification failed");
		$finish;
	end
endmodule
